@@ sv/mhpq_pkg.sv @@
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int LINK_W     = IDX_W + 2;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic [1:0]               status;
        logic [CNT_W-1:0]         occupancy;
    } res_t;

    typedef struct packed {
        logic                     wr_en;
        logic [IDX_W-1:0]         wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        logic [IDX_W-1:0]         rd_addr;
    } mem_req_t;

endpackage

@@ sv/max_heap_priority_queue.sv @@
// A refused request goes straight to the result state. An insert reads the parent and
// compares once per level climbed; an extract reads the root and the last element,
// then reads the children and compares once per level descended. The pace is set by
// the single read port of the element store with registered read data.
// Throughput: one request at a time; the next is taken the cycle after the result
// moves into the output register. Reset: heap empty, no result pending, store undefined.
module max_heap_priority_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mhpq_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output mhpq_pkg::res_t res
);

    logic                               seq_ready;
    logic                               done_valid;
    logic                               done_take;
    mhpq_pkg::res_t                     done_res;
    mhpq_pkg::mem_req_t                 mem_req;
    logic signed [mhpq_pkg::DATA_W-1:0] rd_data;
    logic                               res_valid_reg;
    mhpq_pkg::res_t                     res_reg;

    assign cmd_stall = !seq_ready;
    // advance a finished result whenever the output register is free or draining
    assign done_take = done_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    mhpq_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (seq_ready),
        .cmd        (cmd),
        .done_valid (done_valid),
        .done_take  (done_take),
        .done_res   (done_res),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    mhpq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (done_take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            res_reg <= done_res;
        end
    end

endmodule

@@ sv/mhpq_mem.sv @@
// Heap element store: one write port, one read port with registered data.
module mhpq_mem (
    input  logic                             clk,
    input  mhpq_pkg::mem_req_t               req,
    output logic signed [mhpq_pkg::DATA_W-1:0] rd_data
);

    logic signed [mhpq_pkg::DATA_W-1:0] mem [mhpq_pkg::HEAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

@@ sv/mhpq_seq.sv @@
// Sift-up / sift-down sequencer with the shared compare and the element count.
module mhpq_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  mhpq_pkg::cmd_t                    cmd,
    output logic                              done_valid,
    input  logic                              done_take,
    output mhpq_pkg::res_t                    done_res,
    output mhpq_pkg::mem_req_t                mem_req,
    input  logic signed [mhpq_pkg::DATA_W-1:0] rd_data
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_INS_RD  = 11'b00000000010,
        S_INS_CMP = 11'b00000000100,
        S_EXT_RT  = 11'b00000001000,
        S_EXT_MV  = 11'b00000010000,
        S_DN_RL   = 11'b00000100000,
        S_DN_RR   = 11'b00001000000,
        S_DN_CMP  = 11'b00010000000,
        S_DN_ONE  = 11'b00100000000,
        S_DN_FIN  = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t                              state_reg, state_next;
    logic [mhpq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [mhpq_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic signed [mhpq_pkg::DATA_W-1:0]  key_reg, key_next;
    logic signed [mhpq_pkg::DATA_W-1:0]  top_reg, top_next;
    logic signed [mhpq_pkg::DATA_W-1:0]  hl_reg, hl_next;
    logic [1:0]                          status_reg, status_next;

    logic [mhpq_pkg::IDX_W-1:0]          parent;
    logic [mhpq_pkg::LINK_W-1:0]         left_w, right_w, remain_w;
    logic                                key_le;

    assign parent   = (idx_reg - mhpq_pkg::IDX_W'(1)) >> 1;
    assign left_w   = {1'b0, idx_reg, 1'b1};
    assign right_w  = left_w + mhpq_pkg::LINK_W'(1);
    assign remain_w = mhpq_pkg::LINK_W'(count_reg);
    // Shared compare: held key against the word just read.
    assign key_le   = (key_reg <= rd_data);

    assign cmd_ready  = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_DONE);
    assign done_res   = '{max_value: top_reg, status: status_reg, occupancy: count_reg};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        top_next    = top_reg;
        hl_next     = hl_reg;
        status_next = status_reg;
        mem_req     = '{wr_en: 1'b0, wr_addr: idx_reg, wr_data: key_reg,
                        rd_addr: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    top_next    = '0;
                    status_next = mhpq_pkg::STATUS_OK;
                    if (cmd.kind == mhpq_pkg::KIND_INSERT)
                    begin
                        if (count_reg == mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH))
                        begin
                            status_next = mhpq_pkg::STATUS_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            key_next   = cmd.value;
                            idx_next   = count_reg[mhpq_pkg::IDX_W-1:0];
                            count_next = count_reg + mhpq_pkg::CNT_W'(1);
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::STATUS_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // read the root now
                            count_next = count_reg - mhpq_pkg::CNT_W'(1);
                            state_next = S_EXT_RT;
                        end
                    end
                end
            end
            S_INS_RD:
            begin
                mem_req.rd_addr = parent;
                if (idx_reg == '0)
                begin
                    mem_req.wr_en = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_req.wr_en = 1'b1;
                if (key_le)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // move the smaller parent down one level
                    mem_req.wr_data = rd_data;
                    idx_next        = parent;
                    state_next      = S_INS_RD;
                end
            end
            S_EXT_RT:
            begin
                top_next        = rd_data;
                mem_req.rd_addr = count_reg[mhpq_pkg::IDX_W-1:0];
                state_next      = S_EXT_MV;
            end
            S_EXT_MV:
            begin
                key_next   = rd_data;
                idx_next   = '0;
                state_next = S_DN_RL;
            end
            S_DN_RL:
            begin
                mem_req.rd_addr = left_w[mhpq_pkg::IDX_W-1:0];
                if (right_w < remain_w)
                begin
                    state_next = S_DN_RR;
                end
                else if (right_w == remain_w)
                begin
                    state_next = S_DN_ONE;
                end
                else
                begin
                    mem_req.wr_en = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DN_RR:
            begin
                hl_next         = rd_data;
                mem_req.rd_addr = right_w[mhpq_pkg::IDX_W-1:0];
                state_next      = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_req.wr_en = 1'b1;
                if (key_reg >= hl_reg && key_reg >= rd_data)
                begin
                    state_next = S_DONE;
                end
                else if (rd_data <= hl_reg)
                begin
                    // left child wins ties
                    mem_req.wr_data = hl_reg;
                    idx_next        = left_w[mhpq_pkg::IDX_W-1:0];
                    state_next      = S_DN_RL;
                end
                else
                begin
                    mem_req.wr_data = rd_data;
                    idx_next        = right_w[mhpq_pkg::IDX_W-1:0];
                    state_next      = S_DN_RL;
                end
            end
            S_DN_ONE:
            begin
                mem_req.wr_en = 1'b1;
                if (!key_le || key_reg == rd_data)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.wr_data = rd_data;
                    idx_next        = left_w[mhpq_pkg::IDX_W-1:0];
                    state_next      = S_DN_FIN;
                end
            end
            S_DN_FIN:
            begin
                mem_req.wr_en = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (done_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        top_reg    <= top_next;
        hl_reg     <= hl_next;
        status_reg <= status_next;
    end

endmodule
